// File: sv/assert_macros.svh
// Assertion macros shared by the indexed min-heap RTL.
// Depends on nothing; files that check their logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge out of reset.
`define IMH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
// Check that a condition implies another one in the same cycle.
`define IMH_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("%m: assertion failed");
`else
`define IMH_ASSERT(lbl, clk, rst_n, prop)
`define IMH_ASSERT_IMPL(lbl, clk, rst_n, a, b)
`endif
`endif

// File: sv/imh_pkg.sv
// Package for the indexed min-heap: sequencer states, command and status
// codes, and the result word type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;

	localparam int VALUE_W  = 32;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;

	// Command codes; unused codes behave as a peek.
	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DEL_MIN = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_TAG = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MODIFY  = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BAD_TAG = 2'd3;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TAG_RD,
		ST_DM_TAG,
		ST_REMOVE,
		ST_REM_LAST,
		ST_UP_CHK,
		ST_UP_CMP,
		ST_DN_CHK,
		ST_DN_L,
		ST_DN_R,
		ST_DN_DEC,
		ST_RESP
	} state_t;

	// One result word.
	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic                      min_valid;
		logic signed [VALUE_W-1:0] min_value;
	} result_t;

endpackage
`default_nettype wire

// File: sv/imh_ram.sv
// Simple dual-port RAM: one write port and one registered read port.
// Depends on nothing; used for the slot store and the tag map.
`timescale 1ns / 1ps
`default_nettype none
module imh_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: sv/imh_seq.sv
// Heap sequencer: holds the slot store and tag map and walks sift up and sift
// down, one slot-store read at a time. Depends on imh_pkg, imh_ram, macros.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module imh_seq #(
	parameter int ENTRIES = 1024,
	parameter int SW      = 11
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cmd_valid,
	output logic                                     cmd_ready,
	input  wire logic [imh_pkg::CMD_W-1:0]           cmd,
	input  wire logic [SW-1:0]                       tag,
	input  wire logic signed [imh_pkg::VALUE_W-1:0]  value,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output imh_pkg::result_t                         res
);

	localparam int VW = imh_pkg::VALUE_W;
	localparam int HW = SW + VW;

	imh_pkg::state_t state_q, state_d;

	logic [SW-1:0]                s_q, s_d;
	logic [SW-1:0]                cnt_q, cnt_d;
	logic [SW-1:0]                ins_q, ins_d;
	logic signed [VW-1:0]         e_val_q, e_val_d;
	logic [SW-1:0]                e_tag_q, e_tag_d;
	logic [SW-1:0]                old_tag_q, old_tag_d;
	logic signed [VW-1:0]         b_val_q, b_val_d;
	logic [SW-1:0]                b_tag_q, b_tag_d;
	logic [SW-1:0]                b_slot_q, b_slot_d;
	logic [imh_pkg::CMD_W-1:0]    cmd_q, cmd_d;
	logic [imh_pkg::STATUS_W-1:0] status_q, status_d;
	logic signed [VW-1:0]         min_q;

	logic          hm_we;
	logic [SW-1:0] hm_waddr, hm_raddr;
	logic [HW-1:0] hm_wdata, hm_rdata;
	logic          tm_we;
	logic [SW-1:0] tm_waddr, tm_raddr, tm_wdata, tm_rdata;

	logic signed [VW-1:0] rd_val;
	logic [SW-1:0]        rd_tag;
	logic [SW:0]          l_w, r_w, cnt_w;
	logic                 left_ok, right_ok, full, tag_bad, accept;

	// Slot store: {tag, value} per slot. Tag map: slot per tag, zero if absent.
	imh_ram #(.W(HW), .DEPTH(ENTRIES + 1), .AW(SW)) u_heap_ram (
		.clk(clk), .we(hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
		.raddr(hm_raddr), .rdata(hm_rdata)
	);

	imh_ram #(.W(SW), .DEPTH(ENTRIES + 1), .AW(SW)) u_tag_ram (
		.clk(clk), .we(tm_we), .waddr(tm_waddr), .wdata(tm_wdata),
		.raddr(tm_raddr), .rdata(tm_rdata)
	);

	// Decoded read data and child bounds.
	assign rd_val   = $signed(hm_rdata[VW-1:0]);
	assign rd_tag   = hm_rdata[HW-1:VW];
	assign l_w      = {s_q, 1'b0};
	assign r_w      = {s_q, 1'b1};
	assign cnt_w    = {1'b0, cnt_q};
	assign left_ok  = l_w <= cnt_w;
	assign right_ok = r_w <= cnt_w;
	assign full     = (ins_q >= SW'(ENTRIES)) || (cnt_q >= SW'(ENTRIES));
	assign tag_bad  = (tag == '0) || (tag > ins_q);
	assign accept   = cmd_valid && cmd_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			imh_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd)
						imh_pkg::CMD_INSERT:
							state_d = full ? imh_pkg::ST_RESP : imh_pkg::ST_UP_CHK;
						imh_pkg::CMD_DEL_MIN:
							state_d = (cnt_q == '0) ? imh_pkg::ST_RESP : imh_pkg::ST_DM_TAG;
						imh_pkg::CMD_DEL_TAG, imh_pkg::CMD_MODIFY:
							state_d = tag_bad ? imh_pkg::ST_RESP : imh_pkg::ST_TAG_RD;
						default:
							state_d = imh_pkg::ST_RESP;
					endcase
				end
			end
			imh_pkg::ST_TAG_RD: begin
				if (tm_rdata == '0) begin
					state_d = imh_pkg::ST_RESP;
				end else if (cmd_q == imh_pkg::CMD_MODIFY) begin
					state_d = imh_pkg::ST_UP_CHK;
				end else begin
					state_d = imh_pkg::ST_REMOVE;
				end
			end
			imh_pkg::ST_DM_TAG:   state_d = imh_pkg::ST_REMOVE;
			imh_pkg::ST_REMOVE:
				state_d = (s_q == cnt_q) ? imh_pkg::ST_RESP : imh_pkg::ST_REM_LAST;
			imh_pkg::ST_REM_LAST: state_d = imh_pkg::ST_UP_CHK;
			imh_pkg::ST_UP_CHK:
				state_d = (s_q > SW'(1)) ? imh_pkg::ST_UP_CMP : imh_pkg::ST_DN_CHK;
			imh_pkg::ST_UP_CMP:
				state_d = (rd_val > e_val_q) ? imh_pkg::ST_UP_CHK : imh_pkg::ST_DN_CHK;
			imh_pkg::ST_DN_CHK:
				state_d = left_ok ? imh_pkg::ST_DN_L : imh_pkg::ST_RESP;
			imh_pkg::ST_DN_L:
				state_d = right_ok ? imh_pkg::ST_DN_R : imh_pkg::ST_DN_DEC;
			imh_pkg::ST_DN_R:     state_d = imh_pkg::ST_DN_DEC;
			imh_pkg::ST_DN_DEC:
				state_d = (b_slot_q == s_q) ? imh_pkg::ST_RESP : imh_pkg::ST_DN_CHK;
			imh_pkg::ST_RESP: begin
				if (res_ready) begin
					state_d = imh_pkg::ST_IDLE;
				end
			end
			default: state_d = imh_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and datapath register updates.
	always_comb begin
		hm_we     = 1'b0;
		hm_waddr  = s_q;
		hm_wdata  = {e_tag_q, e_val_q};
		hm_raddr  = '0;
		tm_we     = 1'b0;
		tm_waddr  = e_tag_q;
		tm_wdata  = s_q;
		tm_raddr  = tag;
		s_d       = s_q;
		cnt_d     = cnt_q;
		ins_d     = ins_q;
		e_val_d   = e_val_q;
		e_tag_d   = e_tag_q;
		old_tag_d = old_tag_q;
		b_val_d   = b_val_q;
		b_tag_d   = b_tag_q;
		b_slot_d  = b_slot_q;
		cmd_d     = cmd_q;
		status_d  = status_q;
		unique case (state_q)
			imh_pkg::ST_IDLE: begin
				if (accept) begin
					cmd_d     = cmd;
					status_d  = imh_pkg::STAT_OK;
					e_val_d   = value;
					e_tag_d   = tag;
					old_tag_d = tag;
					case (cmd)
						imh_pkg::CMD_INSERT: begin
							if (full) begin
								status_d = imh_pkg::STAT_FULL;
							end else begin
								s_d     = cnt_q + SW'(1);
								cnt_d   = cnt_q + SW'(1);
								ins_d   = ins_q + SW'(1);
								e_tag_d = ins_q + SW'(1);
							end
						end
						imh_pkg::CMD_DEL_MIN: begin
							if (cnt_q == '0) begin
								status_d = imh_pkg::STAT_EMPTY;
							end else begin
								s_d      = SW'(1);
								hm_raddr = SW'(1);
							end
						end
						imh_pkg::CMD_DEL_TAG, imh_pkg::CMD_MODIFY: begin
							if (tag_bad) begin
								status_d = imh_pkg::STAT_BAD_TAG;
							end
						end
						default: begin
							if (cnt_q == '0) begin
								status_d = imh_pkg::STAT_EMPTY;
							end
						end
					endcase
				end
			end
			imh_pkg::ST_TAG_RD: begin
				s_d = tm_rdata;
				if (tm_rdata == '0) begin
					status_d = imh_pkg::STAT_BAD_TAG;
				end
			end
			imh_pkg::ST_DM_TAG: begin
				old_tag_d = rd_tag;
			end
			imh_pkg::ST_REMOVE: begin
				// Free the tag, then pull the last entry into the hole.
				tm_we    = 1'b1;
				tm_waddr = old_tag_q;
				tm_wdata = '0;
				cnt_d    = cnt_q - SW'(1);
				hm_raddr = cnt_q;
			end
			imh_pkg::ST_REM_LAST: begin
				e_val_d = rd_val;
				e_tag_d = rd_tag;
			end
			imh_pkg::ST_UP_CHK: begin
				hm_raddr = s_q >> 1;
			end
			imh_pkg::ST_UP_CMP: begin
				// Parent larger: it moves down into the hole.
				if (rd_val > e_val_q) begin
					hm_we    = 1'b1;
					hm_wdata = hm_rdata;
					tm_we    = 1'b1;
					tm_waddr = rd_tag;
					s_d      = s_q >> 1;
				end
			end
			imh_pkg::ST_DN_CHK: begin
				hm_raddr = l_w[SW-1:0];
				if (!left_ok) begin
					hm_we = 1'b1;
					tm_we = 1'b1;
				end
			end
			imh_pkg::ST_DN_L: begin
				hm_raddr = r_w[SW-1:0];
				if (rd_val < e_val_q) begin
					b_val_d  = rd_val;
					b_tag_d  = rd_tag;
					b_slot_d = l_w[SW-1:0];
				end else begin
					b_val_d  = e_val_q;
					b_tag_d  = e_tag_q;
					b_slot_d = s_q;
				end
			end
			imh_pkg::ST_DN_R: begin
				if (rd_val < b_val_q) begin
					b_val_d  = rd_val;
					b_tag_d  = rd_tag;
					b_slot_d = r_w[SW-1:0];
				end
			end
			imh_pkg::ST_DN_DEC: begin
				hm_we = 1'b1;
				tm_we = 1'b1;
				if (b_slot_q != s_q) begin
					// Smaller child moves up into the hole.
					hm_wdata = {b_tag_q, b_val_q};
					tm_waddr = b_tag_q;
					s_d      = b_slot_q;
				end
			end
			imh_pkg::ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imh_pkg::ST_IDLE;
			cnt_q   <= '0;
			ins_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ins_q   <= ins_d;
		end
	end

	// Payload registers; the root copy follows every write of slot one.
	always_ff @(posedge clk) begin
		s_q       <= s_d;
		e_val_q   <= e_val_d;
		e_tag_q   <= e_tag_d;
		old_tag_q <= old_tag_d;
		b_val_q   <= b_val_d;
		b_tag_q   <= b_tag_d;
		b_slot_q  <= b_slot_d;
		cmd_q     <= cmd_d;
		status_q  <= status_d;
		if (hm_we && (hm_waddr == SW'(1))) begin
			min_q <= $signed(hm_wdata[VW-1:0]);
		end
	end

	// Handshake and result word.
	assign cmd_ready     = state_q == imh_pkg::ST_IDLE;
	assign res_valid     = state_q == imh_pkg::ST_RESP;
	assign res.status    = status_q;
	assign res.min_valid = cnt_q != '0;
	assign res.min_value = (cnt_q != '0) ? min_q : '0;

	`IMH_ASSERT(a_cnt_le_ins, clk, arst_n, cnt_q <= ins_q)
	`IMH_ASSERT_IMPL(a_idle_no_write, clk, arst_n, state_q == imh_pkg::ST_IDLE, !hm_we && !tm_we)
	`IMH_ASSERT_IMPL(a_up_halves, clk, arst_n, (state_q == imh_pkg::ST_UP_CMP) && hm_we, s_d == (s_q >> 1))
	`IMH_ASSERT_IMPL(a_slot_in_heap, clk, arst_n, hm_we, (hm_waddr != '0) && (hm_waddr <= cnt_q))

endmodule
`default_nettype wire

// File: sv/indexed_min_heap_core.sv
// Indexed binary min-heap top level: stream ports and the result register.
// Depends on imh_pkg and imh_seq.
//
//  Channel | Dir | Fields (tdata, lowest bit first)
//  s_*     | in  | command[2:0], tag[TAG_W-1:0], value[31:0], zero pad
//  m_*     | out | status[1:0], min_valid, min_value[31:0], zero pad
//
// One command at a time: a peek or a request rejected at once goes straight
// to the response, and a delete or modify of an absent tag first reads the
// tag map; insert, delete and modify walk the sift path, each level going
// up a parent read and compare and each level going down a child check, the
// left and right child compares and a move decision.
// Reset clears the counts; the tag map needs no clearing since only tags up
// to the insert count are ever looked up.
// A stalled result waits in the output register; the next command is taken
// once the result has moved there.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_core #(
	parameter int ENTRIES = 1024,
	localparam int TAG_W = $clog2(ENTRIES + 1),
	localparam int VW    = imh_pkg::VALUE_W,
	localparam int CW    = imh_pkg::CMD_W,
	localparam int IN_W  = ((CW + TAG_W + VW + 7) / 8) * 8,
	localparam int RES_W = imh_pkg::STATUS_W + 1 + VW,
	localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,  // command, tag, value
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata   // status, min_valid, min_value
);

	logic             res_valid, res_ready;
	imh_pkg::result_t res, out_q;

	imh_seq #(.ENTRIES(ENTRIES), .SW(TAG_W)) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(s_tvalid),
		.cmd_ready(s_tready),
		.cmd(s_tdata[CW-1:0]),
		.tag(s_tdata[CW +: TAG_W]),
		.value($signed(s_tdata[CW + TAG_W +: VW])),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// Output register takes a result whenever it is empty or being drained.
	assign res_ready = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res_ready) begin
			m_tvalid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	// Pack the result word, status in the lowest bits.
	assign m_tdata = {{(OUT_W - RES_W){1'b0}}, out_q.min_value, out_q.min_valid,
		out_q.status};

endmodule
`default_nettype wire
